>>> rtl/core/llcp_pkg.sv
`default_nettype none
package llcp_pkg;

    localparam int UnitFracBits = 30;
    localparam int RootBits = 32;
    localparam int UnitQBits = UnitFracBits + 1;
    localparam int ParamQBits = 34;

    localparam int StDiff = 0;
    localparam int StMag = 1;
    localparam int StTop = 2;
    localparam int StNorm = 3;
    localparam int StSquare = 4;
    localparam int StSum = 5;
    localparam int StSqrt0 = 6;
    localparam int StDivSet = StSqrt0 + RootBits;
    localparam int StDiv0 = StDivSet + 1;
    localparam int StUnit = StDiv0 + UnitQBits;
    localparam int StDotMul = StUnit + 1;
    localparam int StDotSum = StDotMul + 1;
    localparam int StCosMul = StDotSum + 1;
    localparam int StDenom = StCosMul + 1;
    localparam int StParSet = StDenom + 1;
    localparam int StPar0 = StParSet + 1;
    localparam int StParam = StPar0 + ParamQBits;
    localparam int StPaMul = StParam + 1;
    localparam int StPaAdd = StPaMul + 1;
    localparam int StProjMul = StPaAdd + 1;
    localparam int StProjSum = StProjMul + 1;
    localparam int StPbMul = StProjSum + 1;
    localparam int StPbAdd = StPbMul + 1;
    localparam int NumStages = StPbAdd + 1;

    localparam logic [1:0] StatusFound = 2'd0;
    localparam logic [1:0] StatusParallel = 2'd1;
    localparam logic [1:0] StatusZeroLength = 2'd2;

    localparam logic [30:0] MarginReset = 31'd1;
    localparam logic [33:0] ParamLimit = 34'h1_FFFF_FFFF;
    localparam logic signed [71:0] UnitOne = 72'sd1073741824;
    localparam logic signed [71:0] CoordMax = 72'sd2147483647;
    localparam logic signed [71:0] CoordMin = -72'sd2147483648;

    typedef struct {
        logic signed [31:0] sta [3];
        logic signed [31:0] stb [3];
        logic signed [32:0] da [3];
        logic signed [32:0] db [3];
        logic signed [32:0] u [3];
        logic               zero;
        logic               sa [3];
        logic               sb [3];
        logic [32:0]        ma [3];
        logic [32:0]        mb [3];
        logic [1:0]         rsa;
        logic [1:0]         rsb;
        logic [4:0]         lsa;
        logic [4:0]         lsb;
        logic [30:0]        na [3];
        logic [30:0]        nb [3];
        logic [61:0]        sqa [3];
        logic [61:0]        sqb [3];
        logic [63:0]        rema;
        logic [63:0]        remb;
        logic [31:0]        roota;
        logic [31:0]        rootb;
        logic [61:0]        nua [3];
        logic [61:0]        nub [3];
        logic [31:0]        rda [3];
        logic [31:0]        rdb [3];
        logic [30:0]        qa [3];
        logic [30:0]        qb [3];
        logic signed [31:0] ua [3];
        logic signed [31:0] ub [3];
        logic signed [63:0] pc [3];
        logic signed [64:0] pua [3];
        logic signed [64:0] pub [3];
        logic signed [31:0] c;
        logic signed [35:0] udota;
        logic signed [35:0] udotb;
        logic signed [63:0] pcc;
        logic signed [67:0] pcu;
        logic               cbig;
        logic signed [31:0] dnm;
        logic signed [37:0] num;
        logic               par;
        logic               neg;
        logic               satdiv;
        logic [30:0]        dv;
        logic [33:0]        nlo;
        logic [31:0]        rq;
        logic [33:0]        q;
        logic               sat;
        logic signed [34:0] s;
        logic signed [66:0] ps [3];
        logic signed [31:0] pa [3];
        logic signed [32:0] w [3];
        logic signed [64:0] pw [3];
        logic signed [35:0] t;
        logic signed [67:0] pt [3];
        logic signed [31:0] pb [3];
        logic [1:0]         status;
    } pipe_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic             sat;
    } res_t;

    function automatic logic signed [71:0] round_shift(input logic signed [71:0] v);
        logic [71:0] mag;
        logic [71:0] r;
        mag = v[71] ? 72'(-v) : 72'(v);
        r = (mag + (72'd1 << (UnitFracBits - 1))) >> UnitFracBits;
        return v[71] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [32:0] sat32(input logic signed [71:0] v);
        logic [32:0] r;
        if (v > CoordMax)
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < CoordMin)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/line_line_closest_points.sv
// closest points between two 3d lines, signed q16.16 coordinates
// input channel: in_valid / in_stall with twelve coordinate ports; a transfer
// happens at a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with status, both points and saturated
// config channel: cfg_valid / cfg_ready carrying parallel_margin (q1.30);
// cfg_ready is always high, write only while the block is empty
// throughput: one line pair per cycle while in_stall is low, set by the
// fully pipelined square root (32 stages) and the two restoring dividers
// (31 and 34 stages)
// when out_stall holds, one more result goes to a skid register and then
// in_stall rises and the whole pipeline freezes until the skid drains
// reset clears all valid bits, empties the output side and sets the margin
// to 1
`default_nettype none
module line_line_closest_points
    import llcp_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire         [30:0] parallel_margin,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire  signed [31:0] a_start_x,
    input  wire  signed [31:0] a_start_y,
    input  wire  signed [31:0] a_start_z,
    input  wire  signed [31:0] a_end_x,
    input  wire  signed [31:0] a_end_y,
    input  wire  signed [31:0] a_end_z,
    input  wire  signed [31:0] b_start_x,
    input  wire  signed [31:0] b_start_y,
    input  wire  signed [31:0] b_start_z,
    input  wire  signed [31:0] b_end_x,
    input  wire  signed [31:0] b_end_y,
    input  wire  signed [31:0] b_end_z,
    output logic               out_valid,
    input  wire                out_stall,
    output logic        [1:0]  status,
    output logic signed [31:0] point_a_x,
    output logic signed [31:0] point_a_y,
    output logic signed [31:0] point_a_z,
    output logic signed [31:0] point_b_x,
    output logic signed [31:0] point_b_y,
    output logic signed [31:0] point_b_z,
    output logic               saturated
);

    logic [30:0] margin_reg;
    logic [NumStages-1:0] vld_reg;
    pipe_t stg_reg [NumStages];
    logic en;
    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    res_t last_res;
    logic take;

    assign cfg_ready = 1'b1;
    assign en = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MarginReset;
        end
        else if (cfg_valid)
        begin
            margin_reg <= parallel_margin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NumStages-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < NumStages; k++)
    begin : g_stg
        pipe_t nxt;

        if (k == StDiff)
        begin : g_diff
            always_comb
            begin
                nxt = '{default: '0};
                nxt.sta[0] = a_start_x;
                nxt.sta[1] = a_start_y;
                nxt.sta[2] = a_start_z;
                nxt.stb[0] = b_start_x;
                nxt.stb[1] = b_start_y;
                nxt.stb[2] = b_start_z;
                nxt.da[0] = 33'(a_end_x) - 33'(a_start_x);
                nxt.da[1] = 33'(a_end_y) - 33'(a_start_y);
                nxt.da[2] = 33'(a_end_z) - 33'(a_start_z);
                nxt.db[0] = 33'(b_end_x) - 33'(b_start_x);
                nxt.db[1] = 33'(b_end_y) - 33'(b_start_y);
                nxt.db[2] = 33'(b_end_z) - 33'(b_start_z);
                for (int i = 0; i < 3; i++)
                begin
                    nxt.u[i] = 33'(nxt.stb[i]) - 33'(nxt.sta[i]);
                end
                nxt.zero = (a_end_x == a_start_x && a_end_y == a_start_y
                            && a_end_z == a_start_z)
                        || (b_end_x == b_start_x && b_end_y == b_start_y
                            && b_end_z == b_start_z);
            end
        end
        else if (k == StMag)
        begin : g_mag
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.sa[i] = stg_reg[k-1].da[i][32];
                    nxt.sb[i] = stg_reg[k-1].db[i][32];
                    nxt.ma[i] = stg_reg[k-1].da[i][32] ? 33'(-stg_reg[k-1].da[i])
                                                       : 33'(stg_reg[k-1].da[i]);
                    nxt.mb[i] = stg_reg[k-1].db[i][32] ? 33'(-stg_reg[k-1].db[i])
                                                       : 33'(stg_reg[k-1].db[i]);
                end
            end
        end
        else if (k == StTop)
        begin : g_top
            always_comb
            begin : blk
                logic [32:0] topa;
                logic [32:0] topb;
                nxt = stg_reg[k-1];
                topa = stg_reg[k-1].ma[0] | stg_reg[k-1].ma[1] | stg_reg[k-1].ma[2];
                topb = stg_reg[k-1].mb[0] | stg_reg[k-1].mb[1] | stg_reg[k-1].mb[2];
                nxt.rsa = topa[32] ? 2'd2 : (topa[31] ? 2'd1 : 2'd0);
                nxt.rsb = topb[32] ? 2'd2 : (topb[31] ? 2'd1 : 2'd0);
                nxt.lsa = 5'd0;
                nxt.lsb = 5'd0;
                for (int p = 0; p <= 30; p++)
                begin
                    if (topa[p])
                    begin
                        nxt.lsa = 5'(30 - p);
                    end
                    if (topb[p])
                    begin
                        nxt.lsb = 5'(30 - p);
                    end
                end
                if (topa[32:31] != 2'b00)
                begin
                    nxt.lsa = 5'd0;
                end
                if (topb[32:31] != 2'b00)
                begin
                    nxt.lsb = 5'd0;
                end
            end
        end
        else if (k == StNorm)
        begin : g_norm
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.na[i] = 31'((stg_reg[k-1].ma[i] >> stg_reg[k-1].rsa)
                                    << stg_reg[k-1].lsa);
                    nxt.nb[i] = 31'((stg_reg[k-1].mb[i] >> stg_reg[k-1].rsb)
                                    << stg_reg[k-1].lsb);
                end
            end
        end
        else if (k == StSquare)
        begin : g_square
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.sqa[i] = stg_reg[k-1].na[i] * stg_reg[k-1].na[i];
                    nxt.sqb[i] = stg_reg[k-1].nb[i] * stg_reg[k-1].nb[i];
                end
            end
        end
        else if (k == StSum)
        begin : g_sum
            always_comb
            begin
                nxt = stg_reg[k-1];
                nxt.rema = 64'(stg_reg[k-1].sqa[0]) + 64'(stg_reg[k-1].sqa[1])
                         + 64'(stg_reg[k-1].sqa[2]);
                nxt.remb = 64'(stg_reg[k-1].sqb[0]) + 64'(stg_reg[k-1].sqb[1])
                         + 64'(stg_reg[k-1].sqb[2]);
                nxt.roota = '0;
                nxt.rootb = '0;
            end
        end
        else if (k >= StSqrt0 && k < StDivSet)
        begin : g_sqrt
            localparam int Bit = RootBits - 1 - (k - StSqrt0);
            always_comb
            begin : blk
                logic [65:0] tra;
                logic [65:0] trb;
                nxt = stg_reg[k-1];
                tra = (66'(stg_reg[k-1].roota) << (Bit + 1)) + (66'd1 << (2 * Bit));
                trb = (66'(stg_reg[k-1].rootb) << (Bit + 1)) + (66'd1 << (2 * Bit));
                if (66'(stg_reg[k-1].rema) >= tra)
                begin
                    nxt.rema = 64'(66'(stg_reg[k-1].rema) - tra);
                    nxt.roota[Bit] = 1'b1;
                end
                if (66'(stg_reg[k-1].remb) >= trb)
                begin
                    nxt.remb = 64'(66'(stg_reg[k-1].remb) - trb);
                    nxt.rootb[Bit] = 1'b1;
                end
            end
        end
        else if (k == StDivSet)
        begin : g_divset
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.nua[i] = (62'(stg_reg[k-1].na[i]) << UnitFracBits)
                               + 62'(stg_reg[k-1].roota >> 1);
                    nxt.nub[i] = (62'(stg_reg[k-1].nb[i]) << UnitFracBits)
                               + 62'(stg_reg[k-1].rootb >> 1);
                    nxt.rda[i] = 32'(nxt.nua[i] >> UnitQBits);
                    nxt.rdb[i] = 32'(nxt.nub[i] >> UnitQBits);
                    nxt.qa[i] = '0;
                    nxt.qb[i] = '0;
                end
            end
        end
        else if (k >= StDiv0 && k < StUnit)
        begin : g_div
            localparam int Bit = UnitQBits - 1 - (k - StDiv0);
            always_comb
            begin : blk
                logic [32:0] ca;
                logic [32:0] cb;
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    ca = {stg_reg[k-1].rda[i], stg_reg[k-1].nua[i][Bit]};
                    cb = {stg_reg[k-1].rdb[i], stg_reg[k-1].nub[i][Bit]};
                    if (ca >= 33'(stg_reg[k-1].roota))
                    begin
                        nxt.rda[i] = 32'(ca - 33'(stg_reg[k-1].roota));
                        nxt.qa[i][Bit] = 1'b1;
                    end
                    else
                    begin
                        nxt.rda[i] = ca[31:0];
                    end
                    if (cb >= 33'(stg_reg[k-1].rootb))
                    begin
                        nxt.rdb[i] = 32'(cb - 33'(stg_reg[k-1].rootb));
                        nxt.qb[i][Bit] = 1'b1;
                    end
                    else
                    begin
                        nxt.rdb[i] = cb[31:0];
                    end
                end
            end
        end
        else if (k == StUnit)
        begin : g_unit
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.ua[i] = stg_reg[k-1].sa[i] ? -$signed({1'b0, stg_reg[k-1].qa[i]})
                                                   : $signed({1'b0, stg_reg[k-1].qa[i]});
                    nxt.ub[i] = stg_reg[k-1].sb[i] ? -$signed({1'b0, stg_reg[k-1].qb[i]})
                                                   : $signed({1'b0, stg_reg[k-1].qb[i]});
                end
            end
        end
        else if (k == StDotMul)
        begin : g_dotmul
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.pc[i] = stg_reg[k-1].ua[i] * stg_reg[k-1].ub[i];
                    nxt.pua[i] = stg_reg[k-1].u[i] * stg_reg[k-1].ua[i];
                    nxt.pub[i] = stg_reg[k-1].u[i] * stg_reg[k-1].ub[i];
                end
            end
        end
        else if (k == StDotSum)
        begin : g_dotsum
            always_comb
            begin
                nxt = stg_reg[k-1];
                nxt.c = 32'(round_shift(72'(stg_reg[k-1].pc[0]))
                          + round_shift(72'(stg_reg[k-1].pc[1]))
                          + round_shift(72'(stg_reg[k-1].pc[2])));
                nxt.udota = 36'(round_shift(72'(stg_reg[k-1].pua[0]))
                              + round_shift(72'(stg_reg[k-1].pua[1]))
                              + round_shift(72'(stg_reg[k-1].pua[2])));
                nxt.udotb = 36'(round_shift(72'(stg_reg[k-1].pub[0]))
                              + round_shift(72'(stg_reg[k-1].pub[1]))
                              + round_shift(72'(stg_reg[k-1].pub[2])));
            end
        end
        else if (k == StCosMul)
        begin : g_cosmul
            always_comb
            begin : blk
                logic signed [33:0] absc;
                logic signed [33:0] lim;
                nxt = stg_reg[k-1];
                nxt.pcc = stg_reg[k-1].c * stg_reg[k-1].c;
                nxt.pcu = stg_reg[k-1].c * stg_reg[k-1].udotb;
                absc = stg_reg[k-1].c[31] ? -34'(stg_reg[k-1].c) : 34'(stg_reg[k-1].c);
                lim = 34'sd1073741824 - $signed({3'b000, margin_reg});
                nxt.cbig = absc > lim;
            end
        end
        else if (k == StDenom)
        begin : g_denom
            always_comb
            begin
                nxt = stg_reg[k-1];
                nxt.dnm = 32'(UnitOne - round_shift(72'(stg_reg[k-1].pcc)));
                nxt.num = 38'(72'(stg_reg[k-1].udota) - round_shift(72'(stg_reg[k-1].pcu)));
                nxt.par = stg_reg[k-1].cbig || (nxt.dnm <= 32'sd0);
            end
        end
        else if (k == StParSet)
        begin : g_parset
            always_comb
            begin : blk
                logic [37:0] nmag;
                logic [67:0] nfull;
                nxt = stg_reg[k-1];
                nmag = stg_reg[k-1].num[37] ? 38'(-stg_reg[k-1].num)
                                            : 38'(stg_reg[k-1].num);
                nxt.dv = stg_reg[k-1].dnm[30:0];
                nxt.neg = stg_reg[k-1].num[37];
                nxt.satdiv = nmag >= 38'({stg_reg[k-1].dnm[30:0], 3'b000});
                nfull = (68'(nmag) << UnitFracBits) + 68'(stg_reg[k-1].dnm[30:0] >> 1);
                nxt.nlo = nfull[33:0];
                nxt.rq = 32'(nfull >> ParamQBits);
                nxt.q = '0;
            end
        end
        else if (k >= StPar0 && k < StParam)
        begin : g_pdiv
            localparam int Bit = ParamQBits - 1 - (k - StPar0);
            always_comb
            begin : blk
                logic [32:0] cand;
                nxt = stg_reg[k-1];
                cand = {stg_reg[k-1].rq, stg_reg[k-1].nlo[Bit]};
                if (cand >= 33'(stg_reg[k-1].dv))
                begin
                    nxt.rq = 32'(cand - 33'(stg_reg[k-1].dv));
                    nxt.q[Bit] = 1'b1;
                end
                else
                begin
                    nxt.rq = cand[31:0];
                end
            end
        end
        else if (k == StParam)
        begin : g_param
            always_comb
            begin : blk
                logic [33:0] qs;
                logic qover;
                nxt = stg_reg[k-1];
                qover = stg_reg[k-1].q > ParamLimit;
                nxt.sat = stg_reg[k-1].satdiv || qover;
                qs = nxt.sat ? ParamLimit : stg_reg[k-1].q;
                nxt.s = stg_reg[k-1].neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
            end
        end
        else if (k == StPaMul)
        begin : g_pamul
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.ps[i] = stg_reg[k-1].s * stg_reg[k-1].ua[i];
                end
            end
        end
        else if (k == StPaAdd)
        begin : g_paadd
            always_comb
            begin : blk
                logic [32:0] r;
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    r = sat32(72'(stg_reg[k-1].sta[i]) + round_shift(72'(stg_reg[k-1].ps[i])));
                    nxt.pa[i] = $signed(r[31:0]);
                    nxt.sat = nxt.sat | r[32];
                    nxt.w[i] = 33'(nxt.pa[i]) - 33'(stg_reg[k-1].stb[i]);
                end
            end
        end
        else if (k == StProjMul)
        begin : g_projmul
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.pw[i] = stg_reg[k-1].w[i] * stg_reg[k-1].ub[i];
                end
            end
        end
        else if (k == StProjSum)
        begin : g_projsum
            always_comb
            begin
                nxt = stg_reg[k-1];
                nxt.t = 36'(round_shift(72'(stg_reg[k-1].pw[0]))
                          + round_shift(72'(stg_reg[k-1].pw[1]))
                          + round_shift(72'(stg_reg[k-1].pw[2])));
            end
        end
        else if (k == StPbMul)
        begin : g_pbmul
            always_comb
            begin
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    nxt.pt[i] = stg_reg[k-1].t * stg_reg[k-1].ub[i];
                end
            end
        end
        else
        begin : g_pbadd
            always_comb
            begin : blk
                logic [32:0] r;
                nxt = stg_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    r = sat32(72'(stg_reg[k-1].stb[i]) + round_shift(72'(stg_reg[k-1].pt[i])));
                    nxt.pb[i] = $signed(r[31:0]);
                    nxt.sat = nxt.sat | r[32];
                end
                nxt.status = StatusFound;
                if (stg_reg[k-1].zero || stg_reg[k-1].par)
                begin
                    nxt.status = stg_reg[k-1].zero ? StatusZeroLength : StatusParallel;
                    nxt.sat = 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        nxt.pa[i] = '0;
                        nxt.pb[i] = '0;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[k] <= nxt;
            end
        end
    end

    always_comb
    begin
        last_res.status = stg_reg[NumStages-1].status;
        last_res.sat = stg_reg[NumStages-1].sat;
        for (int i = 0; i < 3; i++)
        begin
            last_res.pa[i] = stg_reg[NumStages-1].pa[i];
            last_res.pb[i] = stg_reg[NumStages-1].pb[i];
        end
    end

    assign take = out_valid_reg && !out_stall;

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg <= vld_reg[NumStages-1];
        end
        else if (vld_reg[NumStages-1])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_reg <= last_res;
        end
        else
        begin
            skid_reg <= last_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_reg.status;
    assign point_a_x = $signed(out_reg.pa[0]);
    assign point_a_y = $signed(out_reg.pa[1]);
    assign point_a_z = $signed(out_reg.pa[2]);
    assign point_b_x = $signed(out_reg.pb[0]);
    assign point_b_y = $signed(out_reg.pb[1]);
    assign point_b_z = $signed(out_reg.pb[2]);
    assign saturated = out_reg.sat;

endmodule
`default_nettype wire

>>> bench/tb_line_line_closest_points.sv
`default_nettype none
module tb_line_line_closest_points;
    import llcp_pkg::*;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        logic               sat;
    } closest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [30:0] parallel_margin = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] a_start_x = '0, a_start_y = '0, a_start_z = '0;
    logic signed [31:0] a_end_x = '0, a_end_y = '0, a_end_z = '0;
    logic signed [31:0] b_start_x = '0, b_start_y = '0, b_start_z = '0;
    logic signed [31:0] b_end_x = '0, b_end_y = '0, b_end_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [31:0] point_a_x, point_a_y, point_a_z;
    logic signed [31:0] point_b_x, point_b_y, point_b_z;
    logic saturated;

    closest_t expected_points [$];
    logic [30:0] margin_q = MarginReset;
    int errors = 0;
    int burst_left = 0;

    line_line_closest_points i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .parallel_margin(parallel_margin),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_start_x(a_start_x), .a_start_y(a_start_y), .a_start_z(a_start_z),
        .a_end_x(a_end_x), .a_end_y(a_end_y), .a_end_z(a_end_z),
        .b_start_x(b_start_x), .b_start_y(b_start_y), .b_start_z(b_start_z),
        .b_end_x(b_end_x), .b_end_y(b_end_y), .b_end_z(b_end_z),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .point_a_x(point_a_x), .point_a_y(point_a_y), .point_a_z(point_a_z),
        .point_b_x(point_b_x), .point_b_y(point_b_y), .point_b_z(point_b_z),
        .saturated(saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint round_back(longint v);
        longint unsigned r;
        r = (mag_of(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void to_unit(input longint d [3], output longint un [3]);
        longint unsigned m [3];
        longint unsigned top, len, q;
        for (int i = 0; i < 3; i++)
            m[i] = mag_of(d[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        while (top >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            top <<= 1;
        end
        len = int_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            un[i] = d[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint dot3(input longint a [3], input longint b [3]);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++)
            s += round_back(a[i] * b[i]);
        return s;
    endfunction

    function automatic closest_t closest_points(input longint as [3], input longint ae [3],
                                                input longint bs [3], input longint be [3]);
        closest_t r;
        longint da [3], db [3], u [3], ua [3], ub [3], w [3], pa [3];
        longint c, mg, dnm, num, s, t;
        longint unsigned nm, qi, qs;
        logic flag;
        flag = 1'b0;
        r.status = StatusFound;
        for (int i = 0; i < 3; i++)
        begin
            da[i] = ae[i] - as[i];
            db[i] = be[i] - bs[i];
            u[i] = bs[i] - as[i];
            r.pa[i] = '0;
            r.pb[i] = '0;
        end
        if ((da[0] == 0 && da[1] == 0 && da[2] == 0) || (db[0] == 0 && db[1] == 0 && db[2] == 0))
            r.status = StatusZeroLength;
        else
        begin
            to_unit(da, ua);
            to_unit(db, ub);
            c = dot3(ua, ub);
            mg = longint'(margin_q);
            dnm = (64'sd1 << 30) - round_back(c * c);
            if (longint'(mag_of(c)) > (64'sd1 << 30) - mg || dnm <= 0)
                r.status = StatusParallel;
            else
            begin
                num = dot3(u, ua) - round_back(c * dot3(u, ub));
                nm = mag_of(num);
                qi = nm / longint'(dnm);
                if (qi >= 8)
                begin
                    qs = ParamLimit;
                    flag = 1'b1;
                end
                else
                begin
                    qs = (qi << 30) + (((nm % longint'(dnm)) << 30) + (dnm >> 1)) / dnm;
                    if (qs > ParamLimit)
                    begin
                        qs = ParamLimit;
                        flag = 1'b1;
                    end
                end
                s = num < 0 ? -longint'(qs) : longint'(qs);
                for (int i = 0; i < 3; i++)
                begin
                    pa[i] = clamp32(as[i] + round_back(s * ua[i]), flag);
                    w[i] = pa[i] - bs[i];
                    r.pa[i] = pa[i][31:0];
                end
                t = dot3(w, ub);
                for (int i = 0; i < 3; i++)
                    r.pb[i] = 32'(clamp32(bs[i] + round_back(t * ub[i]), flag));
            end
        end
        r.sat = flag;
        return r;
    endfunction

    task automatic send_pair(input logic signed [31:0] c [12]);
        longint as [3], ae [3], bs [3], be [3];
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        {a_start_x, a_start_y, a_start_z} <= {c[0], c[1], c[2]};
        {a_end_x, a_end_y, a_end_z} <= {c[3], c[4], c[5]};
        {b_start_x, b_start_y, b_start_z} <= {c[6], c[7], c[8]};
        {b_end_x, b_end_y, b_end_z} <= {c[9], c[10], c[11]};
        for (int i = 0; i < 3; i++)
        begin
            as[i] = c[i];
            ae[i] = c[3 + i];
            bs[i] = c[6 + i];
            be[i] = c[9 + i];
        end
        expected_points.insert(expected_points.size(), closest_points(as, ae, bs, be));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic write_margin(input logic [30:0] v);
        cfg_valid <= 1'b1;
        parallel_margin <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        margin_q = v;
    endtask

    function automatic logic signed [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] c [12];
        c = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000};
        send_pair(c);
        c = '{0, 0, 0, 32'sh10000, 0, 0, 5, 5, 5, 32'sh20000, 3, 0};
        send_pair(c);
        c = '{1, 2, 3, 1, 2, 3, 0, 0, 0, 1, 1, 1};
        send_pair(c);
        c = '{0, 0, 0, 1, 1, 1, 7, 7, 7, 7, 7, 7};
        send_pair(c);
        c = '{0, 0, 0, 1, 1, 1, 7, 7, 7, 7, 7, 7};
        c[9] = 8;
        send_pair(c);
        for (int k = 0; k < 12; k++)
            c[k] = k[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        send_pair(c);
        c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1};
        send_pair(c);
        c = '{0, 0, 0, 100, 0, 0, 32'sh4000_0000, 32'sh4000_0000, 0, 32'sh4000_0000, 32'sh4000_0000, 1};
        send_pair(c);
        c = '{0, 0, 0, 1000, 0, 0, 0, 0, 32'sh7000_0000, 1000, 1, 32'sh7000_0000};
        send_pair(c);
        for (int n = 0; n < 8; n++)
        begin
            for (int k = 0; k < 12; k++)
                c[k] = rand_coord(3);
            send_pair(c);
        end
        drain_and_idle();
    endtask

    task automatic test_random(input int count);
        logic signed [31:0] c [12];
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 3);
            for (int k = 0; k < 12; k++)
                c[k] = rand_coord($urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : kind);
            case ($urandom_range(0, 11))
                0: for (int k = 0; k < 3; k++) c[3 + k] = c[k];
                1: for (int k = 0; k < 3; k++) c[9 + k] = c[6 + k];
                2, 3: for (int k = 0; k < 3; k++)
                    c[9 + k] = c[6 + k] + (c[3 + k] - c[k]) + $signed($urandom_range(0, 2)) - 1;
                default: ;
            endcase
            send_pair(c);
        end
        drain_and_idle();
    endtask

    task automatic test_margins();
        write_margin(31'd0);
        test_random(100);
        write_margin(31'h7FFF_FFFF);
        test_random(40);
        write_margin(31'h4000_0000);
        test_random(40);
        write_margin(31'h0010_0000);
        test_random(150);
        write_margin($urandom_range(0, 32'h0100_0000));
        test_random(150);
        write_margin(MarginReset);
    endtask

    always @(posedge clk)
    begin
        case ($urandom_range(0, 3))
            0: out_stall <= ($urandom_range(0, 1) == 0);
            1: out_stall <= 1'b0;
            default: out_stall <= out_stall && ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        closest_t e;
        logic signed [31:0] got_a [3];
        logic signed [31:0] got_b [3];
        if (rst_n && out_valid && !out_stall)
        begin
            got_a = '{point_a_x, point_a_y, point_a_z};
            got_b = '{point_b_x, point_b_y, point_b_z};
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected transfer, status %0d", $time, status);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated expected %0d actual %0d", $time, e.sat, saturated);
                    errors++;
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (got_a[i] !== e.pa[i])
                    begin
                        $display("%0t: point_a[%0d] expected %0d actual %0d",
                                 $time, i, e.pa[i], got_a[i]);
                        errors++;
                    end
                    if (got_b[i] !== e.pb[i])
                    begin
                        $display("%0t: point_b[%0d] expected %0d actual %0d",
                                 $time, i, e.pb[i], got_b[i]);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200);
        test_margins();
        if (errors == 0 && expected_points.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/llcp_pkg.sv
rtl/core/line_line_closest_points.sv
bench/tb_line_line_closest_points.sv
